// File: hdl/sorted_priority_queue_unit_defines.svh
// assertion macros for the sorted priority queue unit
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SPQ_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spq check failed");

// consequent checked in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spq check failed");

`endif

// File: hdl/spq_pkg.sv
// shared types and constants of the sorted priority queue
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int PRIO_W    = 8;
   localparam int PAYLOAD_W = 16;

   typedef enum logic [1:0] {
      FUNC_INSERT   = 2'd0,
      FUNC_HIGHEST  = 2'd1,
      FUNC_EXACT    = 2'd2,
      FUNC_AT_LEAST = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_REMOVED  = 2'd1,
      STATUS_MISS     = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PUT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [PRIO_W-1:0]    prio;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

   typedef struct packed {
      status_type           status;
      logic [PAYLOAD_W-1:0] payload;
      logic [PRIO_W-1:0]    prio;
   } result_type;

endpackage

`default_nettype wire

// File: hdl/spq_ram.sv
// entry memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
   parameter int CAPACITY = 16
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [$clog2(CAPACITY)-1:0] wr_addr,
   input  wire spq_pkg::entry_type          wr_data,
   input  wire logic                        rd_en,
   input  wire logic [$clog2(CAPACITY)-1:0] rd_addr,
   output spq_pkg::entry_type               rd_data
);
   import spq_pkg::*;

   entry_type mem [CAPACITY];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/spq_ctrl.sv
// sequencer: walks the entry memory to insert or remove one entry
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl #(
   parameter int CAPACITY = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_func,
   input  wire logic [spq_pkg::PRIO_W-1:0]        req_prio,
   input  wire logic [spq_pkg::PAYLOAD_W-1:0]     req_payload,
   output logic                                   res_valid,
   input  wire logic                              res_ready,
   output spq_pkg::result_type                    res,
   output logic [$clog2(CAPACITY+1)-1:0]          fill_count,
   output logic                                   mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0]            mem_rd_addr,
   input  wire spq_pkg::entry_type                mem_rd_data,
   output logic                                   mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0]            mem_wr_addr,
   output spq_pkg::entry_type                     mem_wr_data
);
   import spq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int FW = $clog2(CAPACITY + 1);

   state_type             state_ff, state_in;
   func_type              func_ff, func_in;
   logic [PRIO_W-1:0]     prio_ff, prio_in;
   logic [PAYLOAD_W-1:0]  payload_ff, payload_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic                  found_ff, found_in;
   status_type            status_ff, status_in;
   logic [PAYLOAD_W-1:0]  out_pay_ff, out_pay_in;
   logic [PRIO_W-1:0]     out_prio_ff, out_prio_in;
   logic [FW-1:0]         fill_ff, fill_in;

   logic                  full;
   logic                  empty;
   logic [AW-1:0]         last_idx;
   logic                  at_last;
   logic                  shift_up;
   logic                  match;
   func_type              req_func_t;

   assign req_func_t = func_type'(req_func);
   assign full       = (fill_ff == FW'(CAPACITY));
   assign empty      = (fill_ff == '0);
   assign last_idx   = AW'(fill_ff - FW'(1));
   assign at_last    = (idx_ff == last_idx);
   // insert scan moves entries of lower priority one place toward the tail
   assign shift_up   = (mem_rd_data.prio < prio_ff);

   always_comb begin
      unique case (func_ff)
         FUNC_INSERT:   match = 1'b0;
         FUNC_HIGHEST:  match = (idx_ff == '0);
         FUNC_EXACT:    match = (mem_rd_data.prio == prio_ff);
         FUNC_AT_LEAST: match = (idx_ff == '0) && (mem_rd_data.prio >= prio_ff);
         default:       match = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func_t == FUNC_INSERT) begin
                  if (full) begin
                     state_in = ST_FINISH;
                  end else if (empty) begin
                     state_in = ST_PUT;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else if (empty) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (func_ff == FUNC_INSERT) begin
               if (shift_up) begin
                  state_in = (idx_ff == '0) ? ST_PUT : ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (at_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_PUT:    state_in = ST_FINISH;
         ST_FINISH: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = idx_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff;
      mem_wr_data = mem_rd_data;
      func_in     = func_ff;
      prio_in     = prio_ff;
      payload_in  = payload_ff;
      idx_in      = idx_ff;
      found_in    = found_ff;
      status_in   = status_ff;
      out_pay_in  = out_pay_ff;
      out_prio_in = out_prio_ff;
      fill_in     = fill_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in     = req_func_t;
               prio_in     = req_prio;
               payload_in  = req_payload;
               found_in    = 1'b0;
               status_in   = STATUS_MISS;
               out_pay_in  = '0;
               out_prio_in = '0;
               if (req_func_t == FUNC_INSERT) begin
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else if (!empty) begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = last_idx;
                     idx_in      = last_idx;
                  end
               end else if (!empty) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = '0;
                  idx_in      = '0;
               end
            end
         end
         ST_SCAN: begin
            if (func_ff == FUNC_INSERT) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = idx_ff + AW'(1);
               if (shift_up) begin
                  mem_wr_data = mem_rd_data;
                  if (idx_ff != '0) begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = idx_ff - AW'(1);
                     idx_in      = idx_ff - AW'(1);
                  end
               end else begin
                  mem_wr_data.prio    = prio_ff;
                  mem_wr_data.payload = payload_ff;
                  status_in           = STATUS_INSERTED;
               end
            end else begin
               // after the hit every later entry closes the gap
               if (found_ff) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = idx_ff - AW'(1);
                  mem_wr_data = mem_rd_data;
               end else if (match) begin
                  found_in    = 1'b1;
                  status_in   = STATUS_REMOVED;
                  out_pay_in  = mem_rd_data.payload;
                  out_prio_in = mem_rd_data.prio;
               end
               if (!at_last) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = idx_ff + AW'(1);
                  idx_in      = idx_ff + AW'(1);
               end
            end
         end
         ST_PUT: begin
            mem_wr_en           = 1'b1;
            mem_wr_addr         = '0;
            mem_wr_data.prio    = prio_ff;
            mem_wr_data.payload = payload_ff;
            status_in           = STATUS_INSERTED;
         end
         ST_FINISH: begin
            res_valid = 1'b1;
            if (res_ready) begin
               if (status_ff == STATUS_INSERTED) begin
                  fill_in = fill_ff + FW'(1);
               end else if (status_ff == STATUS_REMOVED) begin
                  fill_in = fill_ff - FW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      prio_ff     <= prio_in;
      payload_ff  <= payload_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      out_pay_ff  <= out_pay_in;
      out_prio_ff <= out_prio_in;
   end

   assign res.status  = status_ff;
   assign res.payload = out_pay_ff;
   assign res.prio    = out_prio_ff;
   assign fill_count  = fill_ff;

endmodule

`default_nettype wire

// File: hdl/sorted_priority_queue_unit.sv
// a full insert or an extract from an empty queue answers without touching the entry memory;
// an insert walks from the tail until it finds its place, any other extract walks every entry
// throughput: one request at a time, set by the one-entry-per-cycle walk over the
// entry memory through its single read port and single write port
// reset empties the queue at once; the entry memory itself is not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit #(
   parameter int CAPACITY = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_priority_req,
   input  wire logic [15:0] req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_payload_out,
   output logic [7:0]       rsp_priority_out
);
   import spq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int FW = $clog2(CAPACITY + 1);

   logic            res_valid;
   logic            res_ready;
   result_type      res;
   logic [FW-1:0]   fill_count;
   logic            mem_rd_en;
   logic [AW-1:0]   mem_rd_addr;
   entry_type       mem_rd_data;
   logic            mem_wr_en;
   logic [AW-1:0]   mem_wr_addr;
   entry_type       mem_wr_data;

   logic            rsp_valid_ff, rsp_valid_in;
   result_type      rsp_ff, rsp_in;

   spq_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_prio    (req_priority_req),
      .req_payload (req_payload),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .fill_count  (fill_count),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   spq_ram #(
      .CAPACITY(CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // response register frees the sequencer while a beat waits downstream
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_payload_out  = rsp_ff.payload;
   assign rsp_priority_out = rsp_ff.prio;

   `SPQ_ASSERT_SAME(a_fill_bound, 1'b1, fill_count <= FW'(CAPACITY))
   `SPQ_ASSERT_SAME(a_full_only_when_full, rsp_valid && (rsp_status == STATUS_FULL),
                    fill_count == FW'(CAPACITY))
   `SPQ_ASSERT_SAME(a_zero_fields, rsp_valid && (rsp_status != STATUS_REMOVED),
                    (rsp_payload_out == '0) && (rsp_priority_out == '0))
   `SPQ_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

endmodule

`default_nettype wire
